/* hw/rtl/btl_pkg.sv */
`timescale 1ns / 1ps
package btl_pkg;

   localparam int MAX_TEXTURE_DIM  = 256;
   localparam int WEIGHT_FRAC_BITS = 15;
   localparam int POS_W            = $clog2(MAX_TEXTURE_DIM);
   localparam int DIM_W            = POS_W + 1;
   localparam int ADDR_W           = 16;
   localparam int STORE_DEPTH      = 1 << ADDR_W;
   localparam int RGB_W            = 24;
   localparam int CHAN_W           = 8;
   localparam int COORD_W          = 26;
   localparam int FRAC_IN_W        = 16;
   localparam int PROD_W           = FRAC_IN_W + DIM_W;
   localparam int WT_W             = WEIGHT_FRAC_BITS + 1;
   localparam int REQ_DATA_W       = 96;
   localparam int CSR_DATA_W       = 24;
   localparam int CSR_INDEX_W      = 2;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int NEIGHBORS        = 4;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TEXTURE_WIDTH  = 2'd0,
      REG_TEXTURE_HEIGHT = 2'd1,
      REG_AMBIENT_COLOR  = 2'd2,
      REG_DIFFUSE_COLOR  = 2'd3
   } reg_index_type;

   typedef struct packed {
      cmd_type                               cmd;
      logic [NEIGHBORS-1:0][ADDR_W-1:0]      addr;
      logic [RGB_W-1:0]                      rgb;
      logic [WEIGHT_FRAC_BITS-1:0]           fu;
      logic [WEIGHT_FRAC_BITS-1:0]           fv;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_TEXTURE_DIM)) r = DIM_W'(MAX_TEXTURE_DIM);
      return r;
   endfunction

endpackage

/* hw/rtl/btl_front.sv */
`timescale 1ns / 1ps
module btl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [btl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic [btl_pkg::DIM_W-1:0]       tex_w,
   input  logic [btl_pkg::DIM_W-1:0]       tex_h,
   input  btl_pkg::qstat_type              q_stat,
   output logic                            push,
   output btl_pkg::entry_type              push_entry
);
   import btl_pkg::*;

   logic                   en;
   logic                   s0_valid_ff, s0_valid_in;
   cmd_type                s0_cmd_ff;
   logic [PROD_W-1:0]      s0_pu_ff, s0_pv_ff;
   logic [ADDR_W-1:0]      s0_index_ff;
   logic [RGB_W-1:0]       s0_rgb_ff;

   logic                   s1_valid_ff, s1_valid_in;
   cmd_type                s1_cmd_ff;
   logic [POS_W-1:0]       s1_tx_ff, s1_xn_ff, s1_ty_ff, s1_yn_ff;
   logic [WEIGHT_FRAC_BITS-1:0] s1_fu_ff, s1_fv_ff;
   logic [ADDR_W-1:0]      s1_index_ff;
   logic [RGB_W-1:0]       s1_rgb_ff;

   logic [COORD_W-1:0]     coord_u, coord_v;
   logic [POS_W-1:0]       tx_in, xn_in, ty_in, yn_in;
   logic [DIM_W+POS_W-1:0] row0, row1;

   function automatic logic [POS_W-1:0] pos_of(input logic [PROD_W-1:0] p,
                                               input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] ip;
      ip = p[PROD_W-1:FRAC_IN_W];
      if (ip > d - DIM_W'(1)) ip = d - DIM_W'(1);
      return ip[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] next_of(input logic [POS_W-1:0] t,
                                                input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] n;
      n = {1'b0, t} + DIM_W'(1);
      if (n >= d) n = '0;
      return n[POS_W-1:0];
   endfunction

   assign coord_u = req_tdata[ADDR_W+RGB_W +: COORD_W];
   assign coord_v = req_tdata[ADDR_W+RGB_W+COORD_W +: COORD_W];

   assign en          = !s1_valid_ff || !q_stat.full;
   assign req_tready  = en;
   assign push        = s1_valid_ff && !q_stat.full;
   assign s0_valid_in = req_tvalid;
   assign s1_valid_in = s0_valid_ff;

   assign tx_in = pos_of(s0_pu_ff, tex_w);
   assign ty_in = pos_of(s0_pv_ff, tex_h);
   assign xn_in = next_of(tx_in, tex_w);
   assign yn_in = next_of(ty_in, tex_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_cmd_ff   <= cmd_type'(req_tuser);
         s0_pu_ff    <= PROD_W'(coord_u[FRAC_IN_W-1:0] * tex_w);
         s0_pv_ff    <= PROD_W'(coord_v[FRAC_IN_W-1:0] * tex_h);
         s0_index_ff <= req_tdata[ADDR_W-1:0];
         s0_rgb_ff   <= req_tdata[ADDR_W +: RGB_W];
         s1_cmd_ff   <= s0_cmd_ff;
         s1_tx_ff    <= tx_in;
         s1_xn_ff    <= xn_in;
         s1_ty_ff    <= ty_in;
         s1_yn_ff    <= yn_in;
         s1_fu_ff    <= s0_pu_ff[FRAC_IN_W-1 -: WEIGHT_FRAC_BITS];
         s1_fv_ff    <= s0_pv_ff[FRAC_IN_W-1 -: WEIGHT_FRAC_BITS];
         s1_index_ff <= s0_index_ff;
         s1_rgb_ff   <= s0_rgb_ff;
      end
   end

   assign row0 = s1_ty_ff * tex_w;
   assign row1 = s1_yn_ff * tex_w;

   always_comb begin
      push_entry.cmd = s1_cmd_ff;
      push_entry.rgb = s1_rgb_ff;
      push_entry.fu  = s1_fu_ff;
      push_entry.fv  = s1_fv_ff;
      if (s1_cmd_ff == CMD_LOAD) begin
         push_entry.addr[0] = s1_index_ff;
      end else begin
         push_entry.addr[0] = ADDR_W'(row0 + DIM_W'(s1_tx_ff));
      end
      push_entry.addr[1] = ADDR_W'(row1 + DIM_W'(s1_tx_ff));
      push_entry.addr[2] = ADDR_W'(row0 + DIM_W'(s1_xn_ff));
      push_entry.addr[3] = ADDR_W'(row1 + DIM_W'(s1_xn_ff));
   end

endmodule

/* hw/rtl/btl_queue.sv */
`timescale 1ns / 1ps
module btl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  btl_pkg::entry_type  push_entry,
   input  logic                pop,
   output btl_pkg::entry_type  pop_entry,
   output btl_pkg::qstat_type  q_stat
);
   import btl_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign q_stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + (QPTR_W+1)'(1))
      else $error("queue push lost");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - (QPTR_W+1)'(1))
      else $error("queue pop lost");

endmodule

/* hw/rtl/btl_back.sv */
`timescale 1ns / 1ps
module btl_back (
   input  logic                              clock,
   input  logic                              reset,
   input  btl_pkg::qstat_type                q_stat,
   output logic                              pop,
   input  btl_pkg::entry_type                pop_entry,
   input  logic [btl_pkg::RGB_W-1:0]         ambient,
   input  logic [btl_pkg::RGB_W-1:0]         diffuse,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [btl_pkg::RGB_W-1:0]         rsp_tdata
);
   import btl_pkg::*;

   localparam int SUM_W = CHAN_W + WT_W + 2;
   localparam logic [WT_W-1:0] ONE = WT_W'(1) << WEIGHT_FRAC_BITS;

   logic [RGB_W-1:0]     mem [NEIGHBORS][STORE_DEPTH];
   logic                 en;
   logic                 b1_valid_ff, b1_valid_in;
   logic [RGB_W-1:0]     b1_px_ff [NEIGHBORS];
   logic [WT_W-1:0]      b1_wt_ff [NEIGHBORS];
   logic [WT_W-1:0]      wt_in [NEIGHBORS];
   logic                 b2_valid_ff;
   logic [CHAN_W-1:0]    b2_t_ff [3];
   logic [CHAN_W-1:0]    t_in [3];
   logic [CHAN_W-1:0]    m_ff [3];
   logic                 out_valid_ff;
   logic [RGB_W-1:0]     out_data_ff, out_data_in;
   logic [WT_W-1:0]      fu, fv, fui, fvi;

   assign en          = !out_valid_ff || rsp_tready;
   assign pop         = !q_stat.empty && en;
   assign b1_valid_in = pop && (pop_entry.cmd == CMD_SAMPLE);
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;

   always_comb begin
      fu  = WT_W'(pop_entry.fu);
      fv  = WT_W'(pop_entry.fv);
      fui = ONE - fu;
      fvi = ONE - fv;
      wt_in[0] = WT_W'((2*WT_W)'(fui * fvi) >> WEIGHT_FRAC_BITS);
      wt_in[1] = WT_W'((2*WT_W)'(fui * fv)  >> WEIGHT_FRAC_BITS);
      wt_in[2] = WT_W'((2*WT_W)'(fu * fvi)  >> WEIGHT_FRAC_BITS);
      wt_in[3] = WT_W'((2*WT_W)'(fu * fv)   >> WEIGHT_FRAC_BITS);
   end

   always_comb begin
      logic [SUM_W-1:0] sum;
      for (int k = 0; k < 3; k++) begin
         sum = '0;
         for (int i = 0; i < NEIGHBORS; i++) begin
            sum = sum + SUM_W'(b1_px_ff[i][k*CHAN_W +: CHAN_W] * b1_wt_ff[i]);
         end
         t_in[k] = sum[WEIGHT_FRAC_BITS +: CHAN_W];
      end
   end

   always_comb begin
      logic [2*CHAN_W-1:0] prod;
      for (int k = 0; k < 3; k++) begin
         prod = b2_t_ff[k] * m_ff[k];
         out_data_in[k*CHAN_W +: CHAN_W] = prod[2*CHAN_W-1:CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      logic [2*CHAN_W-1:0] mp;
      for (int k = 0; k < 3; k++) begin
         mp = ambient[k*CHAN_W +: CHAN_W] * diffuse[k*CHAN_W +: CHAN_W];
         m_ff[k] <= mp[2*CHAN_W-1:CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_entry.cmd == CMD_LOAD) begin
         for (int i = 0; i < NEIGHBORS; i++) begin
            mem[i][pop_entry.addr[0]] <= pop_entry.rgb;
         end
      end
      if (en) begin
         for (int i = 0; i < NEIGHBORS; i++) begin
            b1_px_ff[i] <= mem[i][pop_entry.addr[i]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NEIGHBORS; i++) b1_wt_ff[i] <= wt_in[i];
         for (int k = 0; k < 3; k++) b2_t_ff[k] <= t_in[k];
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!en && b2_valid_ff) |=> b2_valid_ff)
      else $error("stalled stage dropped");
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.cmd == CMD_LOAD) |=> !b1_valid_ff)
      else $error("load produced a result");

endmodule

/* hw/rtl/bilinear_texture_lit_sampler.sv */
`timescale 1ns / 1ps
// A sample passes front s0, s1, the queue, back b1, b2 and the output register to rsp.
// Throughput: one beat (load or sample) per cycle barring queue-full or rsp_tready stalls;
// four texel store copies give four reads. Loads produce no response; a 4-entry queue
// decouples address generation from filtering. Reset: synchronous, active high; clears
// pipeline valids and queue, registers to defaults. Texel store is not cleared by reset.
module bilinear_texture_lit_sampler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // texel_index[15:0], texel_rgb[39:16], coord_u[65:40], coord_v[91:66], zero pad
   input  logic [btl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // lit_color[23:0]
   output logic [btl_pkg::RGB_W-1:0]          rsp_tdata,
   input  logic                               csr_we,
   input  logic [btl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [btl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import btl_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [RGB_W-1:0] ambient_ff, diffuse_ff;
   logic [DIM_W-1:0] tex_w, tex_h;
   qstat_type        q_stat;
   logic             push, pop;
   entry_type        push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_W'(MAX_TEXTURE_DIM);
         height_ff  <= DIM_W'(MAX_TEXTURE_DIM);
         ambient_ff <= '1;
         diffuse_ff <= '1;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_TEXTURE_WIDTH:  width_ff   <= csr_wdata[DIM_W-1:0];
            REG_TEXTURE_HEIGHT: height_ff  <= csr_wdata[DIM_W-1:0];
            REG_AMBIENT_COLOR:  ambient_ff <= csr_wdata[RGB_W-1:0];
            REG_DIFFUSE_COLOR:  diffuse_ff <= csr_wdata[RGB_W-1:0];
            default: ;
         endcase
      end
   end

   assign tex_w = clamp_dim(width_ff);
   assign tex_h = clamp_dim(height_ff);

   btl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .tex_w      (tex_w),
      .tex_h      (tex_h),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   btl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_stat     (q_stat)
   );

   btl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .ambient    (ambient_ff),
      .diffuse    (diffuse_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* dv/bilinear_texture_lit_sampler_checker.sv */
`timescale 1ns / 1ps
module bilinear_texture_lit_sampler_checker
   import btl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RGB_W-1:0]       rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   logic [RGB_W-1:0] texels [STORE_DEPTH];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [RGB_W-1:0] ambient_reg;
   logic [RGB_W-1:0] diffuse_reg;
   logic [RGB_W-1:0] lit_queue [$];

   function automatic int unsigned usable_dim(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_TEXTURE_DIM) return MAX_TEXTURE_DIM;
      return d;
   endfunction

   function automatic logic [RGB_W-1:0] shade(input logic [COORD_W-1:0] u,
                                               input logic [COORD_W-1:0] v);
      int unsigned      w, h, tx, ty, xn, yn, t, m, c;
      longint unsigned  pu, pv, fu, fv, sum;
      longint unsigned  wt [4];
      logic [RGB_W-1:0] px [4];
      logic [RGB_W-1:0] res;
      longint unsigned  one;
      one = longint'(1) << WEIGHT_FRAC_BITS;
      w = usable_dim(width_reg);
      h = usable_dim(height_reg);
      pu = longint'(u[15:0]) * w;
      pv = longint'(v[15:0]) * h;
      tx = pu >> 16;
      ty = pv >> 16;
      if (tx > w - 1) tx = w - 1;
      if (ty > h - 1) ty = h - 1;
      fu = (pu & 64'hFFFF) >> (16 - WEIGHT_FRAC_BITS);
      fv = (pv & 64'hFFFF) >> (16 - WEIGHT_FRAC_BITS);
      wt[0] = ((one - fu) * (one - fv)) >> WEIGHT_FRAC_BITS;
      wt[1] = ((one - fu) * fv) >> WEIGHT_FRAC_BITS;
      wt[2] = (fu * (one - fv)) >> WEIGHT_FRAC_BITS;
      wt[3] = (fu * fv) >> WEIGHT_FRAC_BITS;
      xn = (tx + 1 >= w) ? 0 : tx + 1;
      yn = (ty + 1 >= h) ? 0 : ty + 1;
      px[0] = texels[(ty * w + tx) & 16'hFFFF];
      px[1] = texels[(yn * w + tx) & 16'hFFFF];
      px[2] = texels[(ty * w + xn) & 16'hFFFF];
      px[3] = texels[(yn * w + xn) & 16'hFFFF];
      res = '0;
      for (int k = 0; k < 3; k++) begin
         sum = 0;
         for (int i = 0; i < 4; i++)
            sum += longint'(px[i][8*k +: 8]) * wt[i];
         t = (sum >> WEIGHT_FRAC_BITS) & 8'hFF;
         m = (int'(ambient_reg[8*k +: 8]) * int'(diffuse_reg[8*k +: 8])) >> 8;
         c = ((t * m) >> 8) & 8'hFF;
         res[8*k +: 8] = c[7:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      logic [RGB_W-1:0] want;
      if (reset) begin
         width_reg   <= DIM_W'(256);
         height_reg  <= DIM_W'(256);
         ambient_reg <= 24'hFFFFFF;
         diffuse_reg <= 24'hFFFFFF;
         lit_queue.delete();
         fail_count  <= 0;
         pending     <= 0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_TEXTURE_WIDTH:  width_reg   <= csr_wdata[DIM_W-1:0];
               REG_TEXTURE_HEIGHT: height_reg  <= csr_wdata[DIM_W-1:0];
               REG_AMBIENT_COLOR:  ambient_reg <= csr_wdata[RGB_W-1:0];
               REG_DIFFUSE_COLOR:  diffuse_reg <= csr_wdata[RGB_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (lit_queue.size() == 0) begin
               $error("lit_color unexpected beat, actual %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = lit_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $error("lit_color expected %h actual %h", want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser) == CMD_LOAD)
               texels[req_tdata[15:0]] <= req_tdata[39:16];
            else
               lit_queue.push_back(shade(req_tdata[65:40], req_tdata[91:66]));
         end
         pending <= lit_queue.size();
      end
   end

endmodule

/* dv/bilinear_texture_lit_sampler_test.sv */
`timescale 1ns / 1ps
module bilinear_texture_lit_sampler_test;
   import btl_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES     = 7;
   localparam int PHASE_BEATS = 70;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RGB_W-1:0]       rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   int                     fail_count;
   int                     pending;
   int                     idle_cycles = 0;
   bit                     quiet = 1'b0;
   bit                     loaded [STORE_DEPTH];
   int unsigned            cur_w = 256;
   int unsigned            cur_h = 256;

   always #5 clock = ~clock;

   bilinear_texture_lit_sampler u_top (.*);

   bilinear_texture_lit_sampler_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("bilinear_texture_lit_sampler regression: fail");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_beat(input cmd_type cmd, input logic [REQ_DATA_W-1:0] data);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_texel(input logic [15:0] index, input logic [23:0] rgb);
      send_beat(CMD_LOAD, {4'h0, 26'($urandom()), 26'($urandom()), rgb, index});
      loaded[index] = 1'b1;
   endtask

   function automatic int unsigned clip_dim(input int unsigned d);
      return (d == 0) ? 1 : (d > MAX_TEXTURE_DIM) ? MAX_TEXTURE_DIM : d;
   endfunction

   // fill in any neighbor texel not yet written, then sample
   task automatic sample_at(input logic [25:0] u, input logic [25:0] v);
      int unsigned w, h, tx, ty, xn, yn;
      logic [15:0] addr [4];
      w  = clip_dim(cur_w);
      h  = clip_dim(cur_h);
      tx = (int'(u[15:0]) * w) >> 16;
      ty = (int'(v[15:0]) * h) >> 16;
      xn = (tx + 1 >= w) ? 0 : tx + 1;
      yn = (ty + 1 >= h) ? 0 : ty + 1;
      addr[0] = 16'(ty * w + tx);
      addr[1] = 16'(yn * w + tx);
      addr[2] = 16'(ty * w + xn);
      addr[3] = 16'(yn * w + xn);
      for (int i = 0; i < 4; i++)
         if (!loaded[addr[i]]) load_texel(addr[i], 24'($urandom()));
      send_beat(CMD_SAMPLE, {4'h0, v, u, 40'(($urandom() & 32'hFFFFFF) << 16)});
   endtask

   task automatic program_regs(input int unsigned w, input int unsigned h,
                               input logic [23:0] amb, input logic [23:0] dif);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_TEXTURE_WIDTH;
      csr_wdata <= 24'(w);
      @(posedge clock);
      csr_index <= REG_TEXTURE_HEIGHT;
      csr_wdata <= 24'(h);
      @(posedge clock);
      csr_index <= REG_AMBIENT_COLOR;
      csr_wdata <= amb;
      @(posedge clock);
      csr_index <= REG_DIFFUSE_COLOR;
      csr_wdata <= dif;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_w = w & 9'h1FF;
      cur_h = h & 9'h1FF;
   endtask

   initial begin
      logic [25:0] edge_coords [5];
      edge_coords = '{26'h0, 26'h1FFFFFF, 26'h2000000, 26'h000FFFF, 26'h0008000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      load_texel(16'h0000, 24'h000000);
      load_texel(16'hFFFF, 24'hFFFFFF);
      for (int i = 0; i < 5; i++)
         sample_at(edge_coords[i], edge_coords[(i + 2) % 5]);
      sample_at(26'h0, 26'h0);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: program_regs(1, 1, 24'h000000, 24'hFFFFFF);
            1: program_regs(0, 0, 24'hFFFFFF, 24'h000000);
            2: program_regs(256, 256, 24'($urandom()), 24'($urandom()));
            3: program_regs(511, 300, 24'hFFFFFF, 24'hFFFFFF);
            4: program_regs(3, 5, 24'($urandom()), 24'($urandom()));
            5: program_regs(17, 256, 24'($urandom()), 24'($urandom()));
            default: begin
               quiet = 1'b1;
               program_regs($urandom_range(1, 32), $urandom_range(1, 32),
                            24'($urandom()), 24'($urandom()));
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 9) < 3)
               load_texel(16'($urandom()), 24'($urandom()));
            else
               sample_at(26'($urandom()), 26'($urandom()));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("bilinear_texture_lit_sampler regression: pass");
      else
         $display("bilinear_texture_lit_sampler regression: fail");
      $finish;
   end

endmodule
